>>> hw/rtl/mmsm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared widths, request codes and the control store of the sequencer.
// ----------------------------------------------------------------------------
package mmsm_pkg;

  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 35;
  localparam int DIM_W  = 4;
  localparam int IDX_W  = 3;
  localparam int PC_W   = 4;

  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
  localparam logic [PC_W-1:0] PC_DISP    = 4'd1;
  localparam logic [PC_W-1:0] PC_CHECK   = 4'd2;
  localparam logic [PC_W-1:0] PC_MM_CLR  = 4'd3;
  localparam logic [PC_W-1:0] PC_MM_RD   = 4'd4;
  localparam logic [PC_W-1:0] PC_MM_MUL  = 4'd5;
  localparam logic [PC_W-1:0] PC_MM_ACC  = 4'd6;
  localparam logic [PC_W-1:0] PC_MM_EMIT = 4'd7;
  localparam logic [PC_W-1:0] PC_MM_LOOP = 4'd8;
  localparam logic [PC_W-1:0] PC_SC_RD   = 4'd9;
  localparam logic [PC_W-1:0] PC_SC_MUL  = 4'd10;
  localparam logic [PC_W-1:0] PC_SC_EMIT = 4'd11;
  localparam logic [PC_W-1:0] PC_SC_LOOP = 4'd12;
  localparam logic [PC_W-1:0] PC_ERR     = 4'd13;

  localparam logic [1:0] ADV_NONE = 2'd0;
  localparam logic [1:0] ADV_T    = 2'd1;
  localparam logic [1:0] ADV_COL  = 2'd2;
  localparam logic [1:0] ADV_ROW  = 2'd3;

  localparam logic [1:0] EMIT_NONE = 2'd0;
  localparam logic [1:0] EMIT_MM   = 2'd1;
  localparam logic [1:0] EMIT_SC   = 2'd2;
  localparam logic [1:0] EMIT_ERR  = 2'd3;

  localparam logic [2:0] COND_NEVER    = 3'd0;
  localparam logic [2:0] COND_ALWAYS   = 3'd1;
  localparam logic [2:0] COND_NO_START = 3'd2;
  localparam logic [2:0] COND_SCALAR   = 3'd3;
  localparam logic [2:0] COND_MISMATCH = 3'd4;
  localparam logic [2:0] COND_T_MORE   = 3'd5;
  localparam logic [2:0] COND_MM_DONE  = 3'd6;
  localparam logic [2:0] COND_SC_DONE  = 3'd7;

  typedef struct packed {
    logic            in_rdy;
    logic            idx_clr;
    logic            rd_en;
    logic            rd_scalar;
    logic            mul_en;
    logic            acc_clr;
    logic            acc_en;
    logic [1:0]      adv;
    logic [1:0]      emit;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Control store: one word per step, jump to target when cond holds.
  function automatic ctrl_t mmsm_ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '0;
    unique case (pc)
      PC_IDLE: begin
        c.in_rdy  = 1'b1;
        c.idx_clr = 1'b1;
        c.cond    = COND_NO_START;
        c.target  = PC_IDLE;
      end
      PC_DISP: begin
        c.cond   = COND_SCALAR;
        c.target = PC_SC_RD;
      end
      PC_CHECK: begin
        c.cond   = COND_MISMATCH;
        c.target = PC_ERR;
      end
      PC_MM_CLR: begin
        c.acc_clr = 1'b1;
      end
      PC_MM_RD: begin
        c.rd_en = 1'b1;
      end
      PC_MM_MUL: begin
        c.mul_en = 1'b1;
      end
      PC_MM_ACC: begin
        c.acc_en = 1'b1;
        c.adv    = ADV_T;
        c.cond   = COND_T_MORE;
        c.target = PC_MM_RD;
      end
      PC_MM_EMIT: begin
        c.emit   = EMIT_MM;
        c.adv    = ADV_COL;
        c.cond   = COND_MM_DONE;
        c.target = PC_IDLE;
      end
      PC_MM_LOOP: begin
        c.cond   = COND_ALWAYS;
        c.target = PC_MM_CLR;
      end
      PC_SC_RD: begin
        c.rd_en     = 1'b1;
        c.rd_scalar = 1'b1;
      end
      PC_SC_MUL: begin
        c.mul_en = 1'b1;
      end
      PC_SC_EMIT: begin
        c.emit   = EMIT_SC;
        c.adv    = ADV_ROW;
        c.cond   = COND_SC_DONE;
        c.target = PC_IDLE;
      end
      PC_SC_LOOP: begin
        c.cond   = COND_ALWAYS;
        c.target = PC_SC_RD;
      end
      PC_ERR: begin
        c.emit   = EMIT_ERR;
        c.cond   = COND_ALWAYS;
        c.target = PC_IDLE;
      end
      default: begin
        c.cond   = COND_ALWAYS;
        c.target = PC_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/mmsm_ram.sv
// ----------------------------------------------------------------------------
// Element store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module mmsm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/matrix_multiply_with_scalar_mode_top.sv
// ----------------------------------------------------------------------------
// Integer matrix multiplier with scalar mode
// Loads A and B element by element and streams the product on request.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel (valid/ready). A load request writes
// one element of A or B and completes in the cycle it is taken; a request
// with row or col at or beyond MAX_DIM is dropped. A compute request runs a short
// microprogram and streams results on the out_ channel (valid/ready), the
// final one flagged by out_last. in_ready is low from the compute request
// until its last result has been placed in the output register.
// Each store has a single read port and there is one shared multiplier: a
// scalar-mode element is read, multiplied and emitted; a product element
// clears the accumulator, then reads, multiplies and accumulates each term
// before it is emitted. The user must write dimensions on the cfg_ port
// only while the block is idle; the block itself does not enforce this.
// 0 reads as 1 and values above MAX_DIM as MAX_DIM. Reset sets all dimensions
// to 1 and empties the output register; store contents are not cleared.
// When the receiver stalls, the sequencer holds at its emit step and the
// output register keeps its result.
// ----------------------------------------------------------------------------
module matrix_multiply_with_scalar_mode_top
  import mmsm_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_op,
  input  logic [IDX_W-1:0]        in_row,
  input  logic [IDX_W-1:0]        in_col,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic signed [ACC_W-1:0] out_value,
  output logic                    out_last,
  output logic                    out_error,
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_index,
  input  logic [DIM_W-1:0]        cfg_data
);

  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [IW-1:0] dim_m1(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] c;
    c = d;
    if (d == '0) begin
      c = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      c = DIM_W'(MAX_DIM);
    end
    return IW'(c - DIM_W'(1));
  endfunction

  logic [DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [IW-1:0]    ar_m1, ac_m1, br_m1, bc_m1;

  logic [PC_W-1:0]  pc_r, pc_nxt;
  ctrl_t            cw;
  logic             cond_true, stall, in_fire, emit_fire;

  logic [IW-1:0]    i_r, j_r, t_r;
  logic             i_last, j_last_ac, j_last_bc, t_last, mm_done, sc_done;

  logic                    ld_ok, a_we, b_we;
  logic [6:0]              ld_addr_w, a_rd_w, b_rd_w;
  logic [AW-1:0]           a_raddr, b_raddr;
  logic [VAL_W-1:0]        a_q, b_q;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic                    out_valid_r, out_last_r, out_error_r;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic signed [ACC_W-1:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_W'(1);
      a_cols_r <= DIM_W'(1);
      b_rows_r <= DIM_W'(1);
      b_cols_r <= DIM_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_A_ROWS: a_rows_r <= cfg_data;
        REG_A_COLS: a_cols_r <= cfg_data;
        REG_B_ROWS: b_rows_r <= cfg_data;
        REG_B_COLS: b_cols_r <= cfg_data;
        default:    a_rows_r <= a_rows_r;
      endcase
    end
  end

  assign ar_m1 = dim_m1(a_rows_r);
  assign ac_m1 = dim_m1(a_cols_r);
  assign br_m1 = dim_m1(b_rows_r);
  assign bc_m1 = dim_m1(b_cols_r);

  assign cw       = mmsm_ucode(pc_r);
  assign in_ready = cw.in_rdy;
  assign in_fire  = in_valid && in_ready;

  assign i_last    = (i_r == ar_m1);
  assign j_last_ac = (j_r == ac_m1);
  assign j_last_bc = (j_r == bc_m1);
  assign t_last    = (t_r == ac_m1);
  assign mm_done   = i_last && j_last_bc;
  assign sc_done   = i_last && j_last_ac;

  assign stall     = (cw.emit != EMIT_NONE) && out_valid_r && !out_ready;
  assign emit_fire = (cw.emit != EMIT_NONE) && !stall;

  always_comb begin
    unique case (cw.cond)
      COND_NEVER:    cond_true = 1'b0;
      COND_ALWAYS:   cond_true = 1'b1;
      COND_NO_START: cond_true = !(in_fire && (in_op == OP_COMPUTE));
      COND_SCALAR:   cond_true = (br_m1 == '0) && (bc_m1 == '0);
      COND_MISMATCH: cond_true = (ac_m1 != br_m1);
      COND_T_MORE:   cond_true = !t_last;
      COND_MM_DONE:  cond_true = mm_done;
      COND_SC_DONE:  cond_true = sc_done;
      default:       cond_true = 1'b1;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else if (cond_true) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
      i_r  <= '0;
      j_r  <= '0;
      t_r  <= '0;
    end else begin
      pc_r <= pc_nxt;
      if (cw.idx_clr) begin
        i_r <= '0;
        j_r <= '0;
        t_r <= '0;
      end else if (cw.acc_clr) begin
        t_r <= '0;
      end else if (!stall) begin
        unique case (cw.adv)
          ADV_NONE: t_r <= t_r;
          ADV_T:    t_r <= t_r + IW'(1);
          ADV_COL: begin
            if (i_last) begin
              i_r <= '0;
              j_r <= j_r + IW'(1);
            end else begin
              i_r <= i_r + IW'(1);
            end
          end
          ADV_ROW: begin
            if (j_last_ac) begin
              j_r <= '0;
              i_r <= i_r + IW'(1);
            end else begin
              j_r <= j_r + IW'(1);
            end
          end
          default: t_r <= t_r;
        endcase
      end
    end
  end

  assign ld_ok     = ({1'b0, in_row} < DIM_W'(MAX_DIM)) && ({1'b0, in_col} < DIM_W'(MAX_DIM));
  assign a_we      = in_fire && ld_ok && (in_op == OP_LOAD_A);
  assign b_we      = in_fire && ld_ok && (in_op == OP_LOAD_B);
  assign ld_addr_w = 7'(in_row) * 7'(MAX_DIM) + 7'(in_col);
  assign a_rd_w    = 7'(i_r) * 7'(MAX_DIM) + (cw.rd_scalar ? 7'(j_r) : 7'(t_r));
  assign b_rd_w    = cw.rd_scalar ? 7'd0 : (7'(t_r) * 7'(MAX_DIM) + 7'(j_r));
  assign a_raddr   = a_rd_w[AW-1:0];
  assign b_raddr   = b_rd_w[AW-1:0];

  mmsm_ram #(
    .DEPTH(DEPTH),
    .WIDTH(VAL_W)
  ) u_a_store (
    .clk    (clk),
    .wr_en  (a_we),
    .wr_addr(ld_addr_w[AW-1:0]),
    .wr_data(in_value),
    .rd_en  (cw.rd_en),
    .rd_addr(a_raddr),
    .rd_data(a_q)
  );

  mmsm_ram #(
    .DEPTH(DEPTH),
    .WIDTH(VAL_W)
  ) u_b_store (
    .clk    (clk),
    .wr_en  (b_we),
    .wr_addr(ld_addr_w[AW-1:0]),
    .wr_data(in_value),
    .rd_en  (cw.rd_en),
    .rd_addr(b_raddr),
    .rd_data(b_q)
  );

  always_ff @(posedge clk) begin
    if (cw.mul_en) begin
      prod_r <= $signed(a_q) * $signed(b_q);
    end
    if (cw.acc_clr) begin
      acc_r <= '0;
    end else if (cw.acc_en) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      unique case (cw.emit)
        EMIT_MM: begin
          out_row_r   <= IDX_W'(i_r);
          out_col_r   <= IDX_W'(j_r);
          out_value_r <= acc_r;
          out_last_r  <= mm_done;
          out_error_r <= 1'b0;
        end
        EMIT_SC: begin
          out_row_r   <= IDX_W'(i_r);
          out_col_r   <= IDX_W'(j_r);
          out_value_r <= {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
          out_last_r  <= sc_done;
          out_error_r <= 1'b0;
        end
        default: begin
          out_row_r   <= '0;
          out_col_r   <= '0;
          out_value_r <= '0;
          out_last_r  <= 1'b1;
          out_error_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_error = out_error_r;

`ifndef SYNTHESIS
  a_compute_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_op == OP_COMPUTE)) |=> (pc_r == PC_DISP))
    else $error("compute request did not enter dispatch");

  a_stall_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> (pc_r == $past(pc_r)))
    else $error("sequencer moved while output stalled");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> out_last_r)
    else $error("error result not flagged last");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((pc_r == PC_MM_CLR) || (pc_r == PC_MM_RD) || (pc_r == PC_MM_MUL) ||
     (pc_r == PC_MM_ACC) || (pc_r == PC_MM_EMIT)) |-> (j_r <= bc_m1))
    else $error("product column beyond B width");
`endif

endmodule
